/* sv/tidf_pkg.sv */
`default_nettype none
package tidf_pkg;

	// default ceiling on the fixed output record size
	localparam int unsigned MAX_FIXED_RECORD_DEF = 1048576;

	// field widths
	localparam int unsigned CFG_W   = 21;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned FILL_W  = 21;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// header with this top nibble stops the image
	localparam logic [WORD_W-1:0] MARK_MASK = 32'hF000_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_FILES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_ENABLE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_ONLY = 2'd3;

	// result kinds
	typedef enum logic [2:0] {
		KIND_DATA  = 3'd0,
		KIND_FILL  = 3'd1,
		KIND_MARK  = 3'd2,
		KIND_END   = 3'd3,
		KIND_TRUNC = 3'd4
	} kind_t;

	// one result beat
	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  byte_value;
		logic [FILL_W-1:0]  fill_count;
	} res_t;

	// front to queue write
	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

	// queue to back read side
	typedef struct packed {
		logic valid;
		res_t res;
	} head_t;

endpackage
`default_nettype wire

/* sv/tidf_in_if.sv */
`default_nettype none
interface tidf_in_if
	import tidf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              func;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface
`default_nettype wire

/* sv/tidf_out_if.sv */
`default_nettype none
interface tidf_out_if
	import tidf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic [BYTE_W-1:0] byte_value;
	logic [FILL_W-1:0] fill_count;

	modport source (output valid, output kind, output byte_value, output fill_count, input ready);
	modport sink (input valid, input kind, input byte_value, input fill_count, output ready);
endinterface
`default_nettype wire

/* sv/tidf_front.sv */
`default_nettype none
module tidf_front
	import tidf_pkg::*;
#(
	parameter int unsigned MAX_FIXED_RECORD = MAX_FIXED_RECORD_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	tidf_in_if.sink                   din,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 q_ready,
	output push_t                     push
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_DATA    = 2'd1,
		PH_TRAILER = 2'd2,
		PH_STOPPED = 2'd3
	} phase_t;

	localparam logic [WORD_W-1:0] MaxRec = WORD_W'(MAX_FIXED_RECORD);

	// configuration registers
	logic [CFG_W-1:0]  skip_files_q;
	logic [CFG_W-1:0]  record_size_q;
	logic              pad_enable_q;
	logic              summary_only_q;

	// framing state
	phase_t            phase_q, phase_n;
	logic [WORD_W-1:0] shift_q, shift_n;
	logic [1:0]        hcnt_q, hcnt_n;
	logic [WORD_W-1:0] len_q, len_n;
	logic [WORD_W-1:0] pos_q, pos_n;
	logic [CFG_W-1:0]  skip_q, skip_n;

	logic              accept;
	logic              quiet;
	logic [CFG_W-1:0]  rs;
	logic [WORD_W-1:0] shift_in;
	logic [WORD_W:0]   padded;
	logic [WORD_W-1:0] pos_inc;
	res_t              res;
	logic              res_v;

	assign din.ready = q_ready;
	assign accept    = din.valid && q_ready;
	assign quiet     = (skip_q != '0) || summary_only_q;

	// record size clamped to the ceiling
	assign rs = ({{(WORD_W-CFG_W){1'b0}}, record_size_q} > MaxRec) ?
		MaxRec[CFG_W-1:0] : record_size_q;

	assign shift_in = {din.data_byte, shift_q[WORD_W-1:BYTE_W]};
	assign padded   = {1'b0, len_q} + {{WORD_W{1'b0}}, len_q[0]};
	assign pos_inc  = pos_q + WORD_W'(1);

	// next state and result of one input beat
	always_comb begin
		phase_n = phase_q;
		shift_n = shift_q;
		hcnt_n  = hcnt_q;
		len_n   = len_q;
		pos_n   = pos_q;
		skip_n  = skip_q;
		res     = '{kind: KIND_DATA, byte_value: '0, fill_count: '0};
		res_v   = 1'b0;
		if (din.func) begin
			phase_n = PH_HEADER;
			shift_n = '0;
			hcnt_n  = '0;
			len_n   = '0;
			pos_n   = '0;
			res_v   = (phase_q != PH_STOPPED);
			res.kind = (phase_q == PH_HEADER && hcnt_q == '0) ? KIND_END : KIND_TRUNC;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					shift_n = shift_in;
					if (hcnt_q != 2'd3) begin
						hcnt_n = hcnt_q + 2'd1;
					end else begin
						hcnt_n = '0;
						if (shift_in == '0) begin
							if (skip_q != '0) begin
								skip_n = skip_q - CFG_W'(1);
							end else if (!summary_only_q) begin
								phase_n  = PH_STOPPED;
								res_v    = 1'b1;
								res.kind = KIND_MARK;
							end
						end else if ((shift_in & MARK_MASK) == MARK_MASK) begin
							phase_n  = PH_STOPPED;
							res_v    = 1'b1;
							res.kind = KIND_MARK;
						end else begin
							len_n   = shift_in;
							pos_n   = '0;
							phase_n = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					pos_n = pos_inc;
					if ({1'b0, pos_inc} >= padded) begin
						phase_n = PH_TRAILER;
						hcnt_n  = '0;
						shift_n = '0;
					end
					if (!quiet && pos_q < len_q &&
						(rs == '0 || pos_q < {{(WORD_W-CFG_W){1'b0}}, rs})) begin
						res_v          = 1'b1;
						res.byte_value = din.data_byte;
					end
				end
				PH_TRAILER: begin
					shift_n = shift_in;
					if (hcnt_q != 2'd3) begin
						hcnt_n = hcnt_q + 2'd1;
					end else begin
						phase_n = PH_HEADER;
						shift_n = '0;
						hcnt_n  = '0;
						len_n   = '0;
						pos_n   = '0;
						if (!quiet && pad_enable_q && rs != '0 &&
							len_q < {{(WORD_W-CFG_W){1'b0}}, rs}) begin
							res_v          = 1'b1;
							res.kind       = KIND_FILL;
							res.fill_count = rs - len_q[CFG_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign push.valid = accept && res_v;
	assign push.res   = res;

	// state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			shift_q        <= '0;
			hcnt_q         <= '0;
			len_q          <= '0;
			pos_q          <= '0;
			skip_q         <= '0;
			skip_files_q   <= '0;
			record_size_q  <= '0;
			pad_enable_q   <= 1'b0;
			summary_only_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				shift_q <= shift_n;
				hcnt_q  <= hcnt_n;
				len_q   <= len_n;
				pos_q   <= pos_n;
				skip_q  <= skip_n;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SKIP_FILES: begin
						skip_files_q <= cfg_wdata;
						skip_q       <= cfg_wdata;
					end
					REG_RECORD_SIZE:  record_size_q  <= cfg_wdata;
					REG_PAD_ENABLE:   pad_enable_q   <= cfg_wdata[0];
					REG_SUMMARY_ONLY: summary_only_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
		end
	end

	// a stopped image swallows bytes without results
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_STOPPED) |-> !push.valid)
		else $error("result produced after stop");

	// skip count only falls on a completed zero header
	assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg_we && !(accept && phase_q == PH_HEADER && hcnt_q == 2'd3)) |=>
			$stable(skip_q))
		else $error("skip count changed outside a file mark");

	// skip_files_q is kept as the last written value
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_SKIP_FILES) |=> (skip_q == skip_files_q))
		else $error("skip count not loaded on write");

endmodule
`default_nettype wire

/* sv/tidf_queue.sv */
`default_nettype none
module tidf_queue
	import tidf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  push_t     push,
	input  wire logic pop,
	output logic      q_ready,
	output head_t     head
);

	res_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign q_ready    = (count_q != 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.res   = mem_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wptr_q] <= push.res;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue level out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !push.valid)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

/* sv/tidf_back.sv */
`default_nettype none
module tidf_back
	import tidf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  head_t     head,
	output logic      pop,
	tidf_out_if.source dout
);

	logic valid_q;
	res_t res_q;

	// refill the output register when empty or being taken
	assign pop = head.valid && (!valid_q || dout.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || dout.ready) begin
			valid_q <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head.res;
		end
	end

	assign dout.valid      = valid_q;
	assign dout.kind       = res_q.kind;
	assign dout.byte_value = res_q.byte_value;
	assign dout.fill_count = res_q.fill_count;

endmodule
`default_nettype wire

/* sv/tape_image_record_deframer.sv */
`default_nettype none
// Tape image record deframer. Takes one image byte (or an end-of-image beat) per clock on din
// and gives at most one result per input beat on dout: data bytes, a zero-fill count for short
// records, a stop at a mark, image end, or a truncated record error. Input is taken every
// cycle as long as the two-entry result queue has room; a result passes through a queue write
// and then the output register before it reaches dout, and with dout.ready held high the
// block sustains one beat per cycle. The framing state machine in the front end decides each
// beat combinationally. Configuration is to be written through cfg_we/cfg_index/cfg_wdata
// only while the block is idle (the block itself does not enforce this); writing skip_files
// also reloads the file mark skip count, which otherwise carries over from one image to the next.
module tape_image_record_deframer
	import tidf_pkg::*;
#(
	parameter int unsigned MAX_FIXED_RECORD = MAX_FIXED_RECORD_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	tidf_in_if.sink                   din,
	tidf_out_if.source                dout,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	push_t push;
	head_t head;
	logic  q_ready;
	logic  pop;

	// classify beats and run the framing
	tidf_front #(
		.MAX_FIXED_RECORD(MAX_FIXED_RECORD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_ready   (q_ready),
		.push      (push)
	);

	// decoupling queue
	tidf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.q_ready (q_ready),
		.head    (head)
	);

	// output register
	tidf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.dout   (dout)
	);

endmodule
`default_nettype wire
